// File: rtl/core/mef_pkg.sv
`default_nettype none
package mef_pkg;

   localparam int VERTEX_W          = 6;
   localparam int CAP_IN_W          = 16;
   localparam int FLOW_W            = 22;
   localparam int DEF_MAX_VERTICES  = 64;
   localparam int DEF_CAPACITY_BITS = 16;
   localparam logic [FLOW_W-1:0] FLOW_MAX = 22'd4194303;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_VERTEX_COUNT  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_VERTEX = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SINK_VERTEX   = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_BFS_INIT,
      ST_BFS_POP,
      ST_BFS_POPW,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_WALK_P,
      ST_WALK_PD,
      ST_WALK_R,
      ST_AUG_P,
      ST_AUG_PD,
      ST_AUG_F,
      ST_AUG_R,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic [VERTEX_W-1:0] vertex_count;
      logic [VERTEX_W-1:0] source_vertex;
      logic [VERTEX_W-1:0] sink_vertex;
   } cfg_type;

   typedef struct packed {
      logic [FLOW_W-1:0] flow_value;
      logic              bad_terminals;
   } res_type;

endpackage
`default_nettype wire

// File: rtl/core/mef_engine.sv
`default_nettype none
module mef_engine import mef_pkg::*; #(
   parameter int MAX_VERTICES  = DEF_MAX_VERTICES,
   parameter int CAPACITY_BITS = DEF_CAPACITY_BITS
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                ld_valid,
   output logic                     ld_ready,
   input  wire logic [VERTEX_W-1:0] ld_from,
   input  wire logic [VERTEX_W-1:0] ld_to,
   input  wire logic [CAP_IN_W-1:0] ld_capacity,
   input  wire logic                ld_last,
   input  wire cfg_type             cfg,
   input  wire logic                out_free,
   output logic                     res_valid,
   output res_type                  res
);

   localparam int VW = $clog2(MAX_VERTICES);
   localparam int AW = 2 * VW;
   localparam int RW = CAPACITY_BITS + 1;
   localparam int RD = 1 << AW;
   localparam int VD = 1 << VW;

   logic [RW-1:0] resid_mem [RD];
   logic [VW-1:0] par_mem   [VD];
   logic [VW-1:0] que_mem   [VD];

   logic [RW-1:0] r_rd_ff;
   logic [VW-1:0] p_rd_ff, q_rd_ff;

   state_type         state_ff, state_in;
   logic [AW-1:0]     cnt_ff, cnt_in;
   logic [VW:0]       head_ff, head_in, tail_ff, tail_in;
   logic [VW-1:0]     u_ff, u_in, v_ff, v_in;
   logic [MAX_VERTICES-1:0] vis_ff, vis_in;
   logic [RW-1:0]     bn_ff, bn_in;
   logic [FLOW_W-1:0] flow_ff, flow_in;
   logic              bad_ff, bad_in;

   logic          r_we, p_we, q_we;
   logic [AW-1:0] r_waddr, r_raddr;
   logic [RW-1:0] r_wdata;
   logic [VW-1:0] p_waddr, p_wdata, p_raddr, q_waddr, q_wdata, q_raddr;

   logic [VW-1:0] s_v, t_v, vlast, from_v, to_v;
   logic          s_ok, t_ok, from_ok, to_ok;
   logic [31:0]   cap_wide;
   logic [33:0]   flow_sum;

   function automatic logic vok(input logic [VERTEX_W-1:0] x, input logic [VERTEX_W-1:0] vc);
      return (x != '0) && (x <= vc) && ({3'b000, x} < 9'(MAX_VERTICES));
   endfunction

   assign s_v      = VW'(cfg.source_vertex);
   assign t_v      = VW'(cfg.sink_vertex);
   assign from_v   = VW'(ld_from);
   assign to_v     = VW'(ld_to);
   assign s_ok     = vok(cfg.source_vertex, cfg.vertex_count);
   assign t_ok     = vok(cfg.sink_vertex, cfg.vertex_count);
   assign from_ok  = vok(ld_from, cfg.vertex_count);
   assign to_ok    = vok(ld_to, cfg.vertex_count);
   assign vlast    = ({3'b000, cfg.vertex_count} > 9'(MAX_VERTICES - 1)) ?
                     VW'(MAX_VERTICES - 1) : VW'(cfg.vertex_count);
   assign cap_wide = {16'd0, ld_capacity};
   assign flow_sum = 34'(flow_ff) + 34'(bn_ff);

   assign ld_ready          = (state_ff == ST_IDLE);
   assign res.flow_value    = flow_ff;
   assign res.bad_terminals = bad_ff;

   always_ff @(posedge clock) begin
      if (r_we) begin
         resid_mem[r_waddr] <= r_wdata;
      end
      r_rd_ff <= resid_mem[r_raddr];
      if (p_we) begin
         par_mem[p_waddr] <= p_wdata;
      end
      p_rd_ff <= par_mem[p_raddr];
      if (q_we) begin
         que_mem[q_waddr] <= q_wdata;
      end
      q_rd_ff <= que_mem[q_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
         flow_ff  <= '0;
         bad_ff   <= 1'b0;
         bn_ff    <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         flow_ff  <= flow_in;
         bad_ff   <= bad_in;
         bn_ff    <= bn_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
      u_ff    <= u_in;
      v_ff    <= v_in;
      vis_ff  <= vis_in;
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      u_in      = u_ff;
      v_in      = v_ff;
      vis_in    = vis_ff;
      bn_in     = bn_ff;
      flow_in   = flow_ff;
      bad_in    = bad_ff;
      res_valid = 1'b0;
      r_we      = 1'b0;
      r_waddr   = {u_ff, v_ff};
      r_wdata   = '0;
      r_raddr   = {u_ff, v_ff};
      p_we      = 1'b0;
      p_waddr   = v_ff;
      p_wdata   = u_ff;
      p_raddr   = v_ff;
      q_we      = 1'b0;
      q_waddr   = tail_ff[VW-1:0];
      q_wdata   = v_ff;
      q_raddr   = head_ff[VW-1:0];
      case (state_ff)
         ST_CLEAR: begin
            r_we    = 1'b1;
            r_waddr = cnt_ff;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (ld_valid) begin
               r_we    = from_ok && to_ok;
               r_waddr = {from_v, to_v};
               r_wdata = {1'b0, cap_wide[CAPACITY_BITS-1:0]};
               if (ld_last) begin
                  flow_in = '0;
                  bad_in  = (cfg.source_vertex == cfg.sink_vertex);
                  if ((cfg.source_vertex == cfg.sink_vertex) || !s_ok || !t_ok) begin
                     state_in = ST_RESULT;
                  end else begin
                     state_in = ST_BFS_INIT;
                  end
               end
            end
         end
         ST_BFS_INIT: begin
            vis_in      = '0;
            vis_in[s_v] = 1'b1;
            q_we        = 1'b1;
            q_waddr     = '0;
            q_wdata     = s_v;
            p_we        = 1'b1;
            p_waddr     = s_v;
            p_wdata     = s_v;
            head_in     = '0;
            tail_in     = (VW+1)'(1);
            state_in    = ST_BFS_POP;
         end
         ST_BFS_POP: begin
            if (head_ff == tail_ff) begin
               if (vis_ff[t_v]) begin
                  bn_in    = '1;
                  v_in     = t_v;
                  state_in = ST_WALK_P;
               end else begin
                  state_in = ST_RESULT;
               end
            end else begin
               state_in = ST_BFS_POPW;
            end
         end
         ST_BFS_POPW: begin
            u_in     = q_rd_ff;
            head_in  = head_ff + 1'b1;
            v_in     = VW'(1);
            state_in = ST_SCAN_RD;
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (!vis_ff[v_ff] && (r_rd_ff != '0) &&
                (tail_ff < (VW+1)'(MAX_VERTICES))) begin
               q_we         = 1'b1;
               p_we         = 1'b1;
               vis_in[v_ff] = 1'b1;
               tail_in      = tail_ff + 1'b1;
            end
            if (v_ff == vlast) begin
               state_in = ST_BFS_POP;
            end else begin
               v_in     = v_ff + 1'b1;
               state_in = ST_SCAN_RD;
            end
         end
         ST_WALK_P: begin
            if (v_ff == s_v) begin
               v_in     = t_v;
               state_in = ST_AUG_P;
            end else begin
               state_in = ST_WALK_PD;
            end
         end
         ST_WALK_PD: begin
            u_in     = p_rd_ff;
            r_raddr  = {p_rd_ff, v_ff};
            state_in = ST_WALK_R;
         end
         ST_WALK_R: begin
            if (r_rd_ff < bn_ff) begin
               bn_in = r_rd_ff;
            end
            v_in     = u_ff;
            state_in = ST_WALK_P;
         end
         ST_AUG_P: begin
            if (v_ff == s_v) begin
               if (flow_sum >= 34'(FLOW_MAX)) begin
                  flow_in = FLOW_MAX;
               end else begin
                  flow_in = flow_sum[FLOW_W-1:0];
               end
               state_in = ST_BFS_INIT;
            end else begin
               state_in = ST_AUG_PD;
            end
         end
         ST_AUG_PD: begin
            u_in     = p_rd_ff;
            r_raddr  = {p_rd_ff, v_ff};
            state_in = ST_AUG_F;
         end
         ST_AUG_F: begin
            r_we     = 1'b1;
            r_waddr  = {u_ff, v_ff};
            r_wdata  = r_rd_ff - bn_ff;
            r_raddr  = {v_ff, u_ff};
            state_in = ST_AUG_R;
         end
         ST_AUG_R: begin
            r_we     = 1'b1;
            r_waddr  = {v_ff, u_ff};
            r_wdata  = r_rd_ff + bn_ff;
            v_in     = u_ff;
            state_in = ST_AUG_P;
         end
         ST_RESULT: begin
            if (out_free) begin
               res_valid = 1'b1;
               cnt_in    = '0;
               state_in  = ST_CLEAR;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            cnt_in   = '0;
         end
      endcase
   end

endmodule
`default_nettype wire

// File: rtl/core/max_flow_edmonds_karp_top.sv
`default_nettype none
// channel   direction  handshake            payload
// req_      in         req_valid/req_stall  from_vertex, to_vertex, capacity, last_entry
// rsp_      out        rsp_valid/rsp_stall  flow_value, bad_terminals
// csr_      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// Entries load one per cycle into the residual memory while req_stall is low; the last
// entry starts the search. Each BFS pops each dequeued vertex and checks each scanned
// vertex (min(vertex_count, MAX_VERTICES-1) scanned per dequeued vertex); each
// augmenting path is walked edge by edge, all bound by the single residual port. A
// clearing pass after reset and after each result zeroes 2**(2*clog2(MAX_VERTICES))
// residual entries (4096 at defaults); req_stall stays high meanwhile.
module max_flow_edmonds_karp_top import mef_pkg::*; #(
   parameter int MAX_VERTICES  = DEF_MAX_VERTICES,
   parameter int CAPACITY_BITS = DEF_CAPACITY_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [VERTEX_W-1:0]    req_from_vertex,
   input  wire logic [VERTEX_W-1:0]    req_to_vertex,
   input  wire logic [CAP_IN_W-1:0]    req_capacity,
   input  wire logic                   req_last_entry,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [FLOW_W-1:0]           rsp_flow_value,
   output logic                        rsp_bad_terminals,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [VERTEX_W-1:0]    csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   logic    rsp_valid_ff, rsp_valid_in;
   res_type rsp_ff, rsp_in;
   logic    ld_ready, res_valid;
   res_type res;

   assign csr_ready         = 1'b1;
   assign req_stall         = !ld_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_flow_value    = rsp_ff.flow_value;
   assign rsp_bad_terminals = rsp_ff.bad_terminals;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_VERTEX_COUNT:  cfg_in.vertex_count  = csr_wdata;
            CSR_SOURCE_VERTEX: cfg_in.source_vertex = csr_wdata;
            CSR_SINK_VERTEX:   cfg_in.sink_vertex   = csr_wdata;
            default: begin
            end
         endcase
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.vertex_count  <= 6'd63;
         cfg_ff.source_vertex <= 6'd1;
         cfg_ff.sink_vertex   <= 6'd2;
         rsp_valid_ff         <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   mef_engine #(
      .MAX_VERTICES  (MAX_VERTICES),
      .CAPACITY_BITS (CAPACITY_BITS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .ld_valid    (req_valid),
      .ld_ready    (ld_ready),
      .ld_from     (req_from_vertex),
      .ld_to       (req_to_vertex),
      .ld_capacity (req_capacity),
      .ld_last     (req_last_entry),
      .cfg         (cfg_ff),
      .out_free    (!rsp_valid_ff),
      .res_valid   (res_valid),
      .res         (res)
   );

endmodule
`default_nettype wire

// File: tb/max_flow_edmonds_karp_top_test.sv
module max_flow_edmonds_karp_top_test;
   import mef_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct {
      logic [VERTEX_W-1:0] from_vertex;
      logic [VERTEX_W-1:0] to_vertex;
      logic [CAP_IN_W-1:0] capacity;
      logic                last_entry;
   } entry_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [VERTEX_W-1:0] req_from_vertex = '0;
   logic [VERTEX_W-1:0] req_to_vertex = '0;
   logic [CAP_IN_W-1:0] req_capacity = '0;
   logic req_last_entry = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   logic [FLOW_W-1:0] rsp_flow_value;
   logic rsp_bad_terminals;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [VERTEX_W-1:0] csr_wdata = '0;

   entry_type entry_q[$];
   res_type flow_expected_q[$];
   longint unsigned cap_store[64][64];
   cfg_type graph_cfg;
   int send_idle_pct = 10;
   int recv_idle_pct = 61;
   logic long_hold = 1'b0;
   int errors = 0;
   int entries_made = 0;

   max_flow_edmonds_karp_top i_dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic bit vertex_in_use(logic [VERTEX_W-1:0] v);
      return v >= 1 && v <= graph_cfg.vertex_count;
   endfunction

   function automatic res_type solve_flow();
      bit seen[64];
      int par[64];
      int fifo[64];
      int head, tail, u, v, s, t;
      longint unsigned neck;
      longint unsigned total;
      res_type r;
      r = '0;
      s = graph_cfg.source_vertex;
      t = graph_cfg.sink_vertex;
      total = 0;
      if (s == t) begin
         r.bad_terminals = 1'b1;
      end else if (vertex_in_use(s) && vertex_in_use(t)) begin
         forever begin
            foreach (seen[i]) seen[i] = 1'b0;
            head = 0;
            tail = 1;
            fifo[0] = s;
            seen[s] = 1'b1;
            par[s] = s;
            while (head < tail) begin
               u = fifo[head];
               head++;
               for (v = 1; v <= graph_cfg.vertex_count; v++) begin
                  if (!seen[v] && cap_store[u][v] > 0 && tail < 64) begin
                     fifo[tail] = v;
                     tail++;
                     par[v] = u;
                     seen[v] = 1'b1;
                  end
               end
            end
            if (!seen[t]) break;
            neck = 64'hFFFF_FFFF_FFFF_FFFF;
            for (v = t; v != s; v = par[v])
               if (cap_store[par[v]][v] < neck) neck = cap_store[par[v]][v];
            for (v = t; v != s; v = par[v]) begin
               cap_store[par[v]][v] -= neck;
               cap_store[v][par[v]] += neck;
            end
            if (neck >= FLOW_MAX - total) total = FLOW_MAX;
            else total += neck;
         end
         r.flow_value = total[FLOW_W-1:0];
      end
      return r;
   endfunction

   // driver: predict on each accepted transaction, then advance
   always @(posedge clock) begin
      entry_type e;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            if (vertex_in_use(req_from_vertex) && vertex_in_use(req_to_vertex))
               cap_store[req_from_vertex][req_to_vertex] = req_capacity;
            if (req_last_entry) begin
               flow_expected_q.push_back(solve_flow());
               foreach (cap_store[i, j]) cap_store[i][j] = 0;
            end
         end
         if (!req_valid || !req_stall) begin
            if (entry_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               e = entry_q.pop_front();
               req_from_vertex <= e.from_vertex;
               req_to_vertex <= e.to_vertex;
               req_capacity <= e.capacity;
               req_last_entry <= e.last_entry;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      res_type x;
      if (reset) begin
         rsp_stall <= 1'b1;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (flow_expected_q.size() == 0) begin
               $error("unexpected result: flow_value %0d", rsp_flow_value);
               errors++;
            end else begin
               x = flow_expected_q.pop_front();
               if (rsp_flow_value !== x.flow_value) begin
                  $error("flow_value expected %0d actual %0d", x.flow_value, rsp_flow_value);
                  errors++;
               end
               if (rsp_bad_terminals !== x.bad_terminals) begin
                  $error("bad_terminals expected %0d actual %0d",
                         x.bad_terminals, rsp_bad_terminals);
                  errors++;
               end
            end
         end
         rsp_stall <= long_hold || ($urandom_range(99) < recv_idle_pct);
      end
   end

   // long receiver hold-off so the block backs up
   initial begin
      wait (!reset);
      repeat (40000) @(posedge clock);
      long_hold <= 1'b1;
      repeat (20000) @(posedge clock);
      long_hold <= 1'b0;
   end

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [VERTEX_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_VERTEX_COUNT: graph_cfg.vertex_count = val;
         CSR_SOURCE_VERTEX: graph_cfg.source_vertex = val;
         CSR_SINK_VERTEX: graph_cfg.sink_vertex = val;
         default: ;
      endcase
   endtask

   task automatic set_graph(int vc, int s, int t);
      write_reg(CSR_VERTEX_COUNT, VERTEX_W'(vc));
      write_reg(CSR_SOURCE_VERTEX, VERTEX_W'(s));
      write_reg(CSR_SINK_VERTEX, VERTEX_W'(t));
   endtask

   task automatic add_entry(int f, int t, int c, bit last);
      entry_type e;
      e.from_vertex = VERTEX_W'(f);
      e.to_vertex = VERTEX_W'(t);
      e.capacity = CAP_IN_W'(c);
      e.last_entry = last;
      entry_q.push_back(e);
      entries_made++;
   endtask

   task automatic wait_drained();
      wait (entry_q.size() == 0 && !req_valid && flow_expected_q.size() == 0);
      repeat (50) @(posedge clock);
   endtask

   task automatic random_graph();
      int n, f, t, c, vc;
      vc = graph_cfg.vertex_count;
      n = $urandom_range(12, 2);
      for (int k = 0; k < n; k++) begin
         if (vc > 0 && $urandom_range(99) < 85) begin
            f = ($urandom_range(99) < 30) ? graph_cfg.source_vertex : $urandom_range(vc, 1);
            t = ($urandom_range(99) < 30) ? graph_cfg.sink_vertex : $urandom_range(vc, 1);
         end else begin
            f = $urandom_range(63);
            t = $urandom_range(63);
         end
         case ($urandom_range(5))
            0: c = 0;
            1: c = 16'hFFFF;
            2, 3: c = $urandom_range(65535);
            default: c = $urandom_range(20, 1);
         endcase
         add_entry(f, t, c, k == n - 1);
      end
   endtask

   task automatic random_phase(int sidle, int ridle, int quota);
      int vc, s, t, start;
      send_idle_pct = sidle;
      recv_idle_pct = ridle;
      start = entries_made;
      while (entries_made - start < quota) begin
         wait_drained();
         case ($urandom_range(19))
            0: vc = 63;
            1, 2: vc = $urandom_range(20, 9);
            default: vc = $urandom_range(8, 2);
         endcase
         s = $urandom_range(vc, 1);
         do t = $urandom_range(vc, 1); while (t == s);
         case ($urandom_range(9))
            0: t = s;
            1: t = $urandom_range(63);
            default: ;
         endcase
         set_graph(vc, s, t);
         repeat (4) random_graph();
      end
   endtask

   initial begin
      graph_cfg.vertex_count = 63;
      graph_cfg.source_vertex = 1;
      graph_cfg.sink_vertex = 2;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      add_entry(1, 2, 16'hFFFF, 0);
      add_entry(1, 3, 100, 0);
      add_entry(3, 2, 100, 0);
      add_entry(0, 2, 5, 0);
      add_entry(63, 2, 7, 0);
      add_entry(1, 63, 9, 0);
      add_entry(2, 1, 40, 1);
      wait_drained();
      set_graph(4, 1, 4);
      add_entry(5, 4, 50, 0);
      add_entry(1, 2, 30, 0);
      add_entry(2, 4, 20, 0);
      add_entry(1, 3, 10, 0);
      add_entry(3, 4, 65535, 0);
      add_entry(2, 0, 99, 1);
      wait_drained();
      set_graph(4, 3, 3);
      add_entry(3, 1, 8, 1);
      wait_drained();
      set_graph(5, 7, 2);
      add_entry(1, 2, 8, 1);
      wait_drained();
      set_graph(0, 1, 2);
      add_entry(1, 2, 8, 1);
      wait_drained();
      write_reg(CSR_SPARE, 6'h2A);
      set_graph(63, 63, 1);
      add_entry(63, 1, 16'hFFFF, 0);
      add_entry(63, 40, 16'hFFFF, 0);
      add_entry(40, 1, 16'hFFFF, 1);

      random_phase(10, 61, 200);
      random_phase(61, 10, 200);
      random_phase(0, 0, 200);
      wait_drained();
      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// File: max_flow_edmonds_karp_top.f
rtl/core/mef_pkg.sv
rtl/core/mef_engine.sv
rtl/core/max_flow_edmonds_karp_top.sv
tb/max_flow_edmonds_karp_top_test.sv
